// File: src/hcd_pkg.sv
// Shared types and constants for the held chord hotkey detector.
package hcd_pkg;

    localparam int KEY_W     = 7;
    localparam int TIME_W    = 32;
    localparam int HOLD_W    = 16;
    localparam int OP_W      = 2;
    localparam int ENTRY_W   = KEY_W + TIME_W;   // {press time, key}
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int CNT_OUT_W = 4;

    // operation codes on the input tuser
    localparam logic [OP_W-1:0] OP_DOWN  = 2'd0;
    localparam logic [OP_W-1:0] OP_UP    = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;

    // register reset values
    localparam logic [KEY_W-1:0]  ACT_A_RST = 7'd21;
    localparam logic [KEY_W-1:0]  ACT_B_RST = 7'd23;
    localparam logic [HOLD_W-1:0] HOLD_RST  = 16'd1000;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    // per-entry compare results
    typedef struct packed {
        logic key_eq;    // entry key equals the event key
        logic a_ok;      // entry is activation key A, held long enough
        logic b_ok;      // entry is activation key B, held long enough
        logic non_act;   // entry is neither activation key
    } t_cmp_flags;

endpackage

// File: src/hcd_ram.sv
// Generic single write port, single read port RAM with registered read.
module hcd_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hcd_cmp.sv
// Shared per-entry compare unit: key match, hold-age check, activation tests.
module hcd_cmp (
    input  logic [hcd_pkg::ENTRY_W-1:0] i_entry,
    input  logic [hcd_pkg::KEY_W-1:0]   i_key,
    input  logic [hcd_pkg::TIME_W-1:0]  i_now,
    input  logic [hcd_pkg::KEY_W-1:0]   i_act_a,
    input  logic [hcd_pkg::KEY_W-1:0]   i_act_b,
    input  logic [hcd_pkg::HOLD_W-1:0]  i_hold,
    output hcd_pkg::t_cmp_flags         o_flags
);

    logic [hcd_pkg::KEY_W-1:0]  ent_key;
    logic [hcd_pkg::TIME_W-1:0] ent_time;
    logic [hcd_pkg::TIME_W-1:0] age;
    logic                       aged;

    assign ent_key  = i_entry[hcd_pkg::KEY_W-1:0];
    assign ent_time = i_entry[hcd_pkg::ENTRY_W-1:hcd_pkg::KEY_W];

    // wrapping age, modulo 2^32
    assign age  = i_now - ent_time;
    assign aged = age >= {{(hcd_pkg::TIME_W-hcd_pkg::HOLD_W){1'b0}}, i_hold};

    assign o_flags.key_eq  = ent_key == i_key;
    assign o_flags.a_ok    = aged && (ent_key == i_act_a);
    assign o_flags.b_ok    = aged && (ent_key == i_act_b);
    assign o_flags.non_act = (ent_key != i_act_a) && (ent_key != i_act_b);

endmodule

// File: src/held_chord_hotkey_detector.sv
// Top level: held-key list sequencer, config registers and result register.
//
//  channel   dir  handshake                   payload
//  --------  ---  --------------------------  -------------------------------------
//  s_axis    in   s_axis_tvalid/tready        tdata: key_number, now_ms; tuser: op
//  m_axis    out  m_axis_tvalid/tready        tdata: found, action, dropped, count
//  cfg       in   i_cfg_we (no wait)          i_cfg_idx, i_cfg_wdata
//
// Sequencing: with n keys held, all n entries are read and evaluated before the
// result loads, and the next word can be taken once it has loaded; a key-up
// that finds its key adds a shift phase that moves the later entries down. The
// pace is set by the list RAM: one entry read (and on key-up one entry moved)
// per cycle.
// Reset (i_rst_n low, synchronous) empties the list and restores the
// register defaults; list contents are not cleared, the count guards them.
// The result sits in an output register; a new word is taken while it waits,
// and a finished word stalls in its last cycle until that register frees up.
module held_chord_hotkey_detector #(
    parameter int LIST_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // key_number[6:0], now_ms[38:7]
    input  logic [hcd_pkg::OP_W-1:0]        s_axis_tuser,  // operation[1:0]
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // hotkey_found[0], action_key[7:1],
                                                           // dropped[8], held_count[12:9]
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hcd_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int IW = $clog2(LIST_DEPTH);      // list address
    localparam int CW = $clog2(LIST_DEPTH + 1);  // count, holds LIST_DEPTH

    // ---- registers ----
    hcd_pkg::t_state                  r_state, n_state;
    logic [hcd_pkg::OP_W-1:0]         r_op, n_op;
    logic [hcd_pkg::KEY_W-1:0]        r_key, n_key;
    logic [hcd_pkg::TIME_W-1:0]       r_now, n_now;
    logic [CW-1:0]                    r_rd_idx, n_rd_idx;   // next address to read
    logic                             r_ev_vld, n_ev_vld;   // read data valid this cycle
    logic [IW-1:0]                    r_ev_idx, n_ev_idx;   // address of that data
    logic [CW-1:0]                    r_count, n_count;
    logic                             r_hit, n_hit;
    logic                             r_has_a, n_has_a;
    logic                             r_has_b, n_has_b;
    logic                             r_have_act, n_have_act;
    logic [hcd_pkg::KEY_W-1:0]        r_act, n_act;
    logic                             r_out_vld, n_out_vld;
    logic                             r_out_found, n_out_found;
    logic [hcd_pkg::KEY_W-1:0]        r_out_act, n_out_act;
    logic                             r_out_drop, n_out_drop;
    logic [hcd_pkg::CNT_OUT_W-1:0]    r_out_cnt, n_out_cnt;
    logic [hcd_pkg::KEY_W-1:0]        r_act_a;
    logic [hcd_pkg::KEY_W-1:0]        r_act_b;
    logic [hcd_pkg::HOLD_W-1:0]       r_hold;

    // ---- list RAM and compare unit ----
    logic                             ram_we;
    logic [IW-1:0]                    ram_waddr;
    logic [hcd_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                             ram_re;
    logic [hcd_pkg::ENTRY_W-1:0]      ram_rdata;
    hcd_pkg::t_cmp_flags              flags;

    logic                             issue;
    logic                             pipe_done;
    logic                             out_free;

    hcd_ram #(
        .WIDTH (hcd_pkg::ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    hcd_cmp u_cmp (
        .i_entry (ram_rdata),
        .i_key   (r_key),
        .i_now   (r_now),
        .i_act_a (r_act_a),
        .i_act_b (r_act_b),
        .i_hold  (r_hold),
        .o_flags (flags)
    );

    assign s_axis_tready = r_state == hcd_pkg::ST_IDLE;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_cnt, r_out_drop, r_out_act, r_out_found};

    // read one entry per cycle while below the count
    assign issue = (r_state != hcd_pkg::ST_IDLE) && (r_rd_idx < r_count);
    // all reads issued and the last one evaluated
    assign pipe_done = !r_ev_vld && (r_rd_idx >= r_count);
    assign out_free  = !r_out_vld || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_now       = r_now;
        n_rd_idx    = r_rd_idx;
        n_ev_vld    = 1'b0;
        n_ev_idx    = r_ev_idx;
        n_count     = r_count;
        n_hit       = r_hit;
        n_has_a     = r_has_a;
        n_has_b     = r_has_b;
        n_have_act  = r_have_act;
        n_act       = r_act;
        n_out_vld   = r_out_vld;
        n_out_found = r_out_found;
        n_out_act   = r_out_act;
        n_out_drop  = r_out_drop;
        n_out_cnt   = r_out_cnt;
        ram_we      = 1'b0;
        ram_waddr   = r_ev_idx;
        ram_wdata   = ram_rdata;
        ram_re      = issue;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        if (issue) begin
            n_rd_idx = r_rd_idx + CW'(1);
            n_ev_vld = 1'b1;
            n_ev_idx = r_rd_idx[IW-1:0];
        end

        unique case (r_state)
            hcd_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op       = s_axis_tuser;
                    n_key      = s_axis_tdata[hcd_pkg::KEY_W-1:0];
                    n_now      = s_axis_tdata[hcd_pkg::ENTRY_W-1:hcd_pkg::KEY_W];
                    n_rd_idx   = '0;
                    n_hit      = 1'b0;
                    n_has_a    = 1'b0;
                    n_has_b    = 1'b0;
                    n_have_act = 1'b0;
                    n_act      = '0;
                    n_state    = hcd_pkg::ST_SCAN;
                end
            end

            hcd_pkg::ST_SCAN: begin
                if (r_ev_vld) begin
                    unique case (r_op)
                        hcd_pkg::OP_DOWN: begin
                            if (flags.key_eq) begin
                                n_hit = 1'b1;
                            end
                        end
                        hcd_pkg::OP_UP: begin
                            // found: close the gap from the next entry on
                            if (flags.key_eq) begin
                                n_state  = hcd_pkg::ST_SHIFT;
                                n_rd_idx = CW'(r_ev_idx) + CW'(1);
                                n_ev_vld = 1'b0;
                            end
                        end
                        hcd_pkg::OP_CHECK: begin
                            n_has_a = r_has_a || flags.a_ok;
                            n_has_b = r_has_b || flags.b_ok;
                            if (flags.non_act && !r_have_act) begin
                                n_have_act = 1'b1;
                                n_act      = ram_rdata[hcd_pkg::KEY_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                end else if (pipe_done && out_free) begin
                    n_state     = hcd_pkg::ST_IDLE;
                    n_out_vld   = 1'b1;
                    n_out_found = 1'b0;
                    n_out_act   = '0;
                    n_out_drop  = 1'b0;
                    n_out_cnt   = hcd_pkg::CNT_OUT_W'(r_count);
                    unique case (r_op)
                        hcd_pkg::OP_DOWN: begin
                            if (!r_hit) begin
                                if (r_count < CW'(LIST_DEPTH)) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_count[IW-1:0];
                                    ram_wdata = {r_now, r_key};
                                    n_count   = r_count + CW'(1);
                                    n_out_cnt = hcd_pkg::CNT_OUT_W'(r_count + CW'(1));
                                end else begin
                                    n_out_drop = 1'b1;
                                end
                            end
                        end
                        hcd_pkg::OP_CHECK: begin
                            if (r_has_a && r_has_b && r_have_act) begin
                                n_out_found = 1'b1;
                                n_out_act   = r_act;
                            end
                        end
                        default: ;  // key-up not held, or no-op code
                    endcase
                end
            end

            hcd_pkg::ST_SHIFT: begin
                if (r_ev_vld) begin
                    // entry j+1 moves down to j
                    ram_we    = 1'b1;
                    ram_waddr = r_ev_idx - IW'(1);
                    ram_wdata = ram_rdata;
                end else if (pipe_done && out_free) begin
                    n_state     = hcd_pkg::ST_IDLE;
                    n_count     = r_count - CW'(1);
                    n_out_vld   = 1'b1;
                    n_out_found = 1'b0;
                    n_out_act   = '0;
                    n_out_drop  = 1'b0;
                    n_out_cnt   = hcd_pkg::CNT_OUT_W'(r_count - CW'(1));
                end
            end

            default: n_state = hcd_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hcd_pkg::ST_IDLE;
            r_ev_vld  <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_act_a   <= hcd_pkg::ACT_A_RST;
            r_act_b   <= hcd_pkg::ACT_B_RST;
            r_hold    <= hcd_pkg::HOLD_RST;
        end else begin
            r_state   <= n_state;
            r_ev_vld  <= n_ev_vld;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hcd_pkg::CFG_ACT_A: r_act_a <= i_cfg_wdata[hcd_pkg::KEY_W-1:0];
                    hcd_pkg::CFG_ACT_B: r_act_b <= i_cfg_wdata[hcd_pkg::KEY_W-1:0];
                    hcd_pkg::CFG_HOLD:  r_hold  <= i_cfg_wdata[hcd_pkg::HOLD_W-1:0];
                    default: ;  // unmapped index
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_now       <= n_now;
        r_rd_idx    <= n_rd_idx;
        r_ev_idx    <= n_ev_idx;
        r_hit       <= n_hit;
        r_has_a     <= n_has_a;
        r_has_b     <= n_has_b;
        r_have_act  <= n_have_act;
        r_act       <= n_act;
        r_out_found <= n_out_found;
        r_out_act   <= n_out_act;
        r_out_drop  <= n_out_drop;
        r_out_cnt   <= n_out_cnt;
    end

endmodule

// File: src/hcd_checker.sv
// Port-level checker for the held chord hotkey detector, bound to the top level.
module hcd_props #(
    parameter int LIST_DEPTH = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // no result word right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready the cycle after an accept");

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // action key only with a found hotkey, never with a drop
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || m_axis_tdata[7:1] == 7'd0)
                          && !(m_axis_tdata[0] && m_axis_tdata[8]))
        else $error("inconsistent result fields");

    // count never beyond the list depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (LIST_DEPTH > 15) || (int'(m_axis_tdata[12:9]) <= LIST_DEPTH))
        else $error("held count beyond list depth");

endmodule

bind held_chord_hotkey_detector hcd_props #(
    .LIST_DEPTH (LIST_DEPTH)
) u_hcd_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
